// ----- hw/rtl/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg
// Shared constants, types and helper functions for the complex frequency
// shifter and phase modulator.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int PHASE_WIDTH  = 32;
    localparam int ANGLE_W      = 32;
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CORDIC_W     = 34;
    localparam int MUL_A_W      = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
    localparam int PROD_W       = MUL_A_W + CORDIC_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int CFG_W        = (PHASE_WIDTH > 16) ? PHASE_WIDTH : 16;
    localparam int CFG_IDX_W    = 3;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = CORDIC_W'(652032874);

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IQ_SWAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PM_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PM_LEVEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PM_BIAS    = 3'd6;

    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_SHIFT = 2'd1;
    localparam logic [1:0] MODE_PM    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GAIN_RE,
        OP_GAIN_IM,
        OP_CINIT_PM,
        OP_CINIT_ROT,
        OP_CITER,
        OP_PM,
        OP_ROT0,
        OP_ROT1,
        OP_ROT2,
        OP_ROT3,
        OP_OUT_COPY,
        OP_OUT_ROT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic iter_last;
        logic is_shift;
        logic mode_pm;
    } dp_status_t;

    // Arctangent table in 32-bit turn units.
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
        logic signed [CORDIC_W-1:0] r;
        begin
            case (i)
                5'd0:    r = CORDIC_W'(536870912);
                5'd1:    r = CORDIC_W'(316933406);
                5'd2:    r = CORDIC_W'(167458907);
                5'd3:    r = CORDIC_W'(85004756);
                5'd4:    r = CORDIC_W'(42667331);
                5'd5:    r = CORDIC_W'(21354465);
                5'd6:    r = CORDIC_W'(10679838);
                5'd7:    r = CORDIC_W'(5340245);
                5'd8:    r = CORDIC_W'(2670163);
                5'd9:    r = CORDIC_W'(1335087);
                5'd10:   r = CORDIC_W'(667544);
                5'd11:   r = CORDIC_W'(333772);
                5'd12:   r = CORDIC_W'(166886);
                5'd13:   r = CORDIC_W'(83443);
                5'd14:   r = CORDIC_W'(41722);
                5'd15:   r = CORDIC_W'(20861);
                5'd16:   r = CORDIC_W'(10430);
                5'd17:   r = CORDIC_W'(5215);
                5'd18:   r = CORDIC_W'(2608);
                5'd19:   r = CORDIC_W'(1304);
                5'd20:   r = CORDIC_W'(652);
                5'd21:   r = CORDIC_W'(326);
                5'd22:   r = CORDIC_W'(163);
                5'd23:   r = CORDIC_W'(81);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Clamp a wide signed value to the signed sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
            lo = -hi - ACC_W'(1);
            if (v > hi)
                return hi[SAMPLE_WIDTH-1:0];
            else if (v < lo)
                return lo[SAMPLE_WIDTH-1:0];
            else
                return v[SAMPLE_WIDTH-1:0];
        end
    endfunction

    // Top 32 bits of the phase accumulator as a turn angle.
    function automatic logic [ANGLE_W-1:0] acc_angle(input logic [PHASE_WIDTH-1:0] p);
        logic [PHASE_WIDTH+ANGLE_W-1:0] wide;
        begin
            wide = {p, {ANGLE_W{1'b0}}};
            return wide[PHASE_WIDTH+ANGLE_W-1 -: ANGLE_W];
        end
    endfunction

endpackage

// ----- hw/rtl/csm_if.sv -----
// ----------------------------------------------------------------------------
// csm_in_if / csm_out_if
// Valid/ready channels carrying one complex sample per item.
// ----------------------------------------------------------------------------
interface csm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [csm_pkg::SAMPLE_WIDTH-1:0]  in_re;
    logic signed [csm_pkg::SAMPLE_WIDTH-1:0]  in_im;

    modport source (output valid, output in_re, output in_im, input ready);
    modport sink   (input valid, input in_re, input in_im, output ready);
endinterface

interface csm_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [csm_pkg::SAMPLE_WIDTH-1:0]  out_re;
    logic signed [csm_pkg::SAMPLE_WIDTH-1:0]  out_im;

    modport source (output valid, output out_re, output out_im, input ready);
    modport sink   (input valid, input out_re, input out_im, output ready);
endinterface

// ----- hw/rtl/csm_datapath.sv -----
// ----------------------------------------------------------------------------
// csm_datapath
// Configuration registers, phase accumulator, shared multiplier, iterative
// CORDIC and output registers.
// ----------------------------------------------------------------------------
module csm_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [csm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]               cfg_data,
    input  logic signed [csm_pkg::SAMPLE_WIDTH-1:0] in_re,
    input  logic signed [csm_pkg::SAMPLE_WIDTH-1:0] in_im,
    input  csm_pkg::dp_cmd_t                        cmd,
    output csm_pkg::dp_status_t                     status,
    output logic signed [csm_pkg::SAMPLE_WIDTH-1:0] out_re,
    output logic signed [csm_pkg::SAMPLE_WIDTH-1:0] out_im
);

    localparam int SW = csm_pkg::SAMPLE_WIDTH;
    localparam int PW = csm_pkg::PHASE_WIDTH;
    localparam int AW = csm_pkg::ANGLE_W;
    localparam int CW = csm_pkg::CORDIC_W;
    localparam int MA = csm_pkg::MUL_A_W;
    localparam int PRW = csm_pkg::PROD_W;
    localparam int ACW = csm_pkg::ACC_W;
    localparam int IW = csm_pkg::ITER_W;

    logic [1:0]              mode_reg;
    logic signed [15:0]      gain_reg;
    logic                    swap_reg;
    logic [PW-1:0]           step_reg;
    logic signed [15:0]      offset_reg;
    logic signed [15:0]      level_reg;
    logic signed [15:0]      bias_reg;
    logic [PW-1:0]           phase_reg;

    logic signed [SW-1:0]    xre_reg, xim_reg;
    logic signed [SW-1:0]    gre_reg, gim_reg;
    logic [AW-1:0]           ang_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg, cz_reg;
    logic                    flip_reg;
    logic [IW-1:0]           iter_reg;
    logic signed [ACW-1:0]   accre_reg, accim_reg;
    logic signed [SW-1:0]    outre_reg, outim_reg;

    logic signed [MA-1:0]    mul_a;
    logic signed [CW-1:0]    mul_b;
    logic signed [PRW-1:0]   prod;
    logic signed [ACW-1:0]   prod_x;
    logic signed [CW-1:0]    cos_val, sin_val;
    logic [AW-1:0]           init_ang, init_t, init_fold;
    logic signed [CW-1:0]    sh_x, sh_y, atan_val;
    logic signed [ACW-1:0]   gain_rnd, pm_rnd, re_rnd, im_rnd;

    assign cos_val = flip_reg ? -cx_reg : cx_reg;
    assign sin_val = flip_reg ? -cy_reg : cy_reg;

    // Operand selection for the single shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            csm_pkg::OP_GAIN_RE:
            begin
                mul_a = swap_reg ? MA'(xim_reg) : MA'(xre_reg);
                mul_b = CW'(gain_reg);
            end
            csm_pkg::OP_GAIN_IM:
            begin
                mul_a = swap_reg ? MA'(xre_reg) : MA'(xim_reg);
                mul_b = CW'(gain_reg);
            end
            csm_pkg::OP_PM:
            begin
                mul_a = MA'(level_reg);
                mul_b = sin_val + (CW'(bias_reg) <<< 16);
            end
            csm_pkg::OP_ROT0:
            begin
                mul_a = MA'(gre_reg);
                mul_b = cos_val;
            end
            csm_pkg::OP_ROT1:
            begin
                mul_a = MA'(gim_reg);
                mul_b = sin_val;
            end
            csm_pkg::OP_ROT2:
            begin
                mul_a = MA'(gre_reg);
                mul_b = sin_val;
            end
            csm_pkg::OP_ROT3:
            begin
                mul_a = MA'(gim_reg);
                mul_b = cos_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = PRW'(mul_a) * PRW'(mul_b);
    assign prod_x   = ACW'(prod);
    assign gain_rnd = (prod_x + ACW'(2048)) >>> 12;
    assign pm_rnd   = (prod_x + ACW'(1024)) >>> 11;
    assign re_rnd   = (accre_reg + (ACW'(1) <<< 29)) >>> 30;
    assign im_rnd   = (accim_reg + (ACW'(1) <<< 29)) >>> 30;

    // Fold the start angle into the right half plane by a half turn.
    assign init_ang  = (cmd.op == csm_pkg::OP_CINIT_PM)
                     ? ang_reg + {offset_reg, 16'b0} : ang_reg;
    assign init_t    = init_ang + 32'h4000_0000;
    assign init_fold = init_ang ^ {init_t[AW-1], {(AW-1){1'b0}}};

    assign sh_x     = cx_reg >>> iter_reg;
    assign sh_y     = cy_reg >>> iter_reg;
    assign atan_val = csm_pkg::atan_turn(iter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= csm_pkg::MODE_COPY;
            gain_reg   <= 16'sd4096;
            swap_reg   <= 1'b0;
            step_reg   <= '0;
            offset_reg <= '0;
            level_reg  <= '0;
            bias_reg   <= '0;
            phase_reg  <= '0;
            iter_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    csm_pkg::REG_MODE:       mode_reg   <= cfg_data[1:0];
                    csm_pkg::REG_GAIN:       gain_reg   <= cfg_data[15:0];
                    csm_pkg::REG_IQ_SWAP:    swap_reg   <= cfg_data[0];
                    csm_pkg::REG_PHASE_STEP: step_reg   <= cfg_data[PW-1:0];
                    csm_pkg::REG_PM_OFFSET:  offset_reg <= cfg_data[15:0];
                    csm_pkg::REG_PM_LEVEL:   level_reg  <= cfg_data[15:0];
                    csm_pkg::REG_PM_BIAS:    bias_reg   <= cfg_data[15:0];
                    default:                 ;
                endcase
            end
            if (cmd.op == csm_pkg::OP_LOAD)
                phase_reg <= phase_reg + step_reg;
            if (cmd.op == csm_pkg::OP_CINIT_PM || cmd.op == csm_pkg::OP_CINIT_ROT)
                iter_reg <= '0;
            else if (cmd.op == csm_pkg::OP_CITER)
                iter_reg <= iter_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            csm_pkg::OP_LOAD:
            begin
                xre_reg <= in_re;
                xim_reg <= in_im;
                ang_reg <= csm_pkg::acc_angle(phase_reg);
            end
            csm_pkg::OP_GAIN_RE: gre_reg <= csm_pkg::sat_sample(gain_rnd);
            csm_pkg::OP_GAIN_IM: gim_reg <= csm_pkg::sat_sample(gain_rnd);
            csm_pkg::OP_CINIT_PM, csm_pkg::OP_CINIT_ROT:
            begin
                cx_reg   <= csm_pkg::CORDIC_K;
                cy_reg   <= '0;
                cz_reg   <= CW'(signed'(init_fold));
                flip_reg <= init_t[AW-1];
            end
            csm_pkg::OP_CITER:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_val;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_val;
                end
            end
            csm_pkg::OP_PM:      ang_reg   <= pm_rnd[AW-1:0];
            csm_pkg::OP_ROT0:    accre_reg <= prod_x;
            csm_pkg::OP_ROT1:    accre_reg <= accre_reg - prod_x;
            csm_pkg::OP_ROT2:    accim_reg <= prod_x;
            csm_pkg::OP_ROT3:    accim_reg <= accim_reg + prod_x;
            csm_pkg::OP_OUT_COPY:
            begin
                outre_reg <= gre_reg;
                outim_reg <= gim_reg;
            end
            csm_pkg::OP_OUT_ROT:
            begin
                outre_reg <= csm_pkg::sat_sample(re_rnd);
                outim_reg <= csm_pkg::sat_sample(im_rnd);
            end
            default: ;
        endcase
    end

    assign status.iter_last = (iter_reg == IW'(csm_pkg::CORDIC_ITERS - 1));
    assign status.is_shift  = (mode_reg == csm_pkg::MODE_SHIFT);
    assign status.mode_pm   = (mode_reg == csm_pkg::MODE_PM);
    assign out_re = outre_reg;
    assign out_im = outim_reg;

endmodule

// ----- hw/rtl/csm_ctrl.sv -----
// ----------------------------------------------------------------------------
// csm_ctrl
// Sequencer for one item: gain, optional PM angle, CORDIC and rotation (not in copy).
// ----------------------------------------------------------------------------
module csm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output csm_pkg::dp_cmd_t    cmd,
    input  csm_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_RE,
        ST_GAIN_IM,
        ST_CINIT_PM,
        ST_CITER_PM,
        ST_PM,
        ST_CINIT_ROT,
        ST_CITER_ROT,
        ST_ROT0,
        ST_ROT1,
        ST_ROT2,
        ST_ROT3,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   rot_reg, rot_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        rot_next       = rot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = csm_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = csm_pkg::OP_LOAD;
                    state_next = ST_GAIN_RE;
                end
            end
            ST_GAIN_RE:
            begin
                cmd.op     = csm_pkg::OP_GAIN_RE;
                state_next = ST_GAIN_IM;
            end
            ST_GAIN_IM:
            begin
                cmd.op   = csm_pkg::OP_GAIN_IM;
                rot_next = status.is_shift || status.mode_pm;
                if (status.mode_pm)
                    state_next = ST_CINIT_PM;
                else if (status.is_shift)
                    state_next = ST_CINIT_ROT;
                else
                    state_next = ST_OUT;
            end
            ST_CINIT_PM:
            begin
                cmd.op     = csm_pkg::OP_CINIT_PM;
                state_next = ST_CITER_PM;
            end
            ST_CITER_PM:
            begin
                cmd.op = csm_pkg::OP_CITER;
                if (status.iter_last)
                    state_next = ST_PM;
            end
            ST_PM:
            begin
                cmd.op     = csm_pkg::OP_PM;
                state_next = ST_CINIT_ROT;
            end
            ST_CINIT_ROT:
            begin
                cmd.op     = csm_pkg::OP_CINIT_ROT;
                state_next = ST_CITER_ROT;
            end
            ST_CITER_ROT:
            begin
                cmd.op = csm_pkg::OP_CITER;
                if (status.iter_last)
                    state_next = ST_ROT0;
            end
            ST_ROT0:
            begin
                cmd.op     = csm_pkg::OP_ROT0;
                state_next = ST_ROT1;
            end
            ST_ROT1:
            begin
                cmd.op     = csm_pkg::OP_ROT1;
                state_next = ST_ROT2;
            end
            ST_ROT2:
            begin
                cmd.op     = csm_pkg::OP_ROT2;
                state_next = ST_ROT3;
            end
            ST_ROT3:
            begin
                cmd.op     = csm_pkg::OP_ROT3;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // The result register is written only once the previous item has left.
                if (slot_free)
                begin
                    cmd.op         = rot_reg ? csm_pkg::OP_OUT_ROT : csm_pkg::OP_OUT_COPY;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rot_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("controller stayed ready after taking an item");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_cordic_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CITER_ROT) && status.iter_last |=> state_reg == ST_ROT0)
        else $error("CORDIC did not hand over to rotation");

endmodule

// ----- hw/rtl/complex_shift_pm_modulator.sv -----
// ----------------------------------------------------------------------------
// complex_shift_pm_modulator
// Complex frequency shifter and phase modulator with a phase accumulator.
// A new sample is taken only in the idle state, once the previous result has
// been written to the output register; a stalled result holds the next one.
// The 24-step CORDIC is run once for shift and twice for PM, and not for copy.
// Reset clears the phase accumulator and loads register defaults (gain 1.0).
// ----------------------------------------------------------------------------
module complex_shift_pm_modulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [csm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]     cfg_data,
    csm_in_if.sink                        din,
    csm_out_if.source                     dout
);

    csm_pkg::dp_cmd_t    cmd;
    csm_pkg::dp_status_t status;

    csm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .cmd       (cmd),
        .status    (status)
    );

    csm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_re     (din.in_re),
        .in_im     (din.in_im),
        .cmd       (cmd),
        .status    (status),
        .out_re    (dout.out_re),
        .out_im    (dout.out_im)
    );

endmodule

// ----- tb/complex_shift_pm_modulator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_shift_pm_modulator_tb
// Self-checking bench for the frequency shifter and phase modulator. It
// starts with a short table of samples and register writes, then runs
// phases of random samples under random register settings. Every result
// is checked against fixed expected values or a bit-exact CORDIC predictor
// kept in the bench, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module complex_shift_pm_modulator_tb;

    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 70;
    localparam int HOLD_LEN  = 400;
    localparam int PHASES    = 14;
    localparam int PHASE_LEN = 124;
    localparam logic [csm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [1:0]                    MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [csm_pkg::CFG_IDX_W-1:0]    idx;
        logic [csm_pkg::CFG_W-1:0]        data;
        logic [csm_pkg::SAMPLE_WIDTH-1:0] re;
        logic [csm_pkg::SAMPLE_WIDTH-1:0] im;
        logic [csm_pkg::SAMPLE_WIDTH-1:0] exp_re;
        logic [csm_pkg::SAMPLE_WIDTH-1:0] exp_im;
    } row_t;

    typedef struct {
        logic [csm_pkg::SAMPLE_WIDTH-1:0] re;
        logic [csm_pkg::SAMPLE_WIDTH-1:0] im;
    } sample_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [csm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [csm_pkg::CFG_W-1:0]     cfg_data;

    csm_in_if  din_if ();
    csm_out_if dout_if ();

    complex_shift_pm_modulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din_if),
        .dout      (dout_if)
    );

    // Predictor state: registers and phase accumulator.
    logic [1:0]                      rot_mode;
    longint                          rot_gain;
    bit                              rot_swap;
    logic [csm_pkg::PHASE_WIDTH-1:0] rot_step;
    longint                          rot_offset;
    longint                          rot_level;
    longint                          rot_bias;
    logic [csm_pkg::PHASE_WIDTH-1:0] rot_acc;

    longint  atan_lut [csm_pkg::CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    sample_t pending_q[$];
    row_t    stim_rows[$];
    int      errors = 0;
    int      cycles = 0;
    bit      no_idle;
    bit      hold_req;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[complex_shift_pm_modulator] ERROR");
            $finish;
        end
    end

    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        else if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] t;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        t = ang + 32'h4000_0000;
        flip = t[31];
        if (flip)
            ang = ang ^ 32'h8000_0000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < csm_pkg::CORDIC_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_lut[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic rotate_sample(input logic [15:0] re, input logic [15:0] im,
                                 output sample_t res);
        longint      xr;
        longint      xi;
        longint      t;
        longint      c;
        longint      s;
        longint      total;
        logic [31:0] ang;
        xr = longint'($signed(re));
        xi = longint'($signed(im));
        if (rot_swap)
        begin
            t = xr;
            xr = xi;
            xi = t;
        end
        xr = clamp16(round_shift(xr * rot_gain, 12));
        xi = clamp16(round_shift(xi * rot_gain, 12));
        ang = rot_acc[csm_pkg::PHASE_WIDTH-1 -: 32];
        if (rot_mode == csm_pkg::MODE_SHIFT || rot_mode == csm_pkg::MODE_PM)
        begin
            if (rot_mode == csm_pkg::MODE_PM)
            begin
                sin_cos(ang + {rot_offset[15:0], 16'h0000}, c, s);
                total = s + rot_bias * 65536;
                t = round_shift(rot_level * total, 11);
                ang = t[31:0];
            end
            sin_cos(ang, c, s);
            t = clamp16(round_shift(xr * c - xi * s, 30));
            res.re = t[15:0];
            t = clamp16(round_shift(xr * s + xi * c, 30));
            res.im = t[15:0];
        end
        else
        begin
            res.re = xr[15:0];
            res.im = xi[15:0];
        end
        rot_acc = rot_acc + rot_step;
    endtask

    // Waits for every result, then for the SETTLE pause, before registers change.
    task automatic settle();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Keeps the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csm_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            csm_pkg::REG_MODE:       rot_mode = data[1:0];
            csm_pkg::REG_GAIN:       rot_gain = longint'($signed(data[15:0]));
            csm_pkg::REG_IQ_SWAP:    rot_swap = data[0];
            csm_pkg::REG_PHASE_STEP: rot_step = data[csm_pkg::PHASE_WIDTH-1:0];
            csm_pkg::REG_PM_OFFSET:  rot_offset = longint'($signed(data[15:0]));
            csm_pkg::REG_PM_LEVEL:   rot_level = longint'($signed(data[15:0]));
            csm_pkg::REG_PM_BIAS:    rot_bias = longint'($signed(data[15:0]));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                               input bit known, input logic [15:0] er,
                               input logic [15:0] ei);
        int      gap;
        sample_t res;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.in_re <= re;
        din_if.in_im <= im;
        do
            @(posedge clk);
        while (!din_if.ready);
        rotate_sample(re, im, res);
        if (known)
        begin
            res.re = er;
            res.im = ei;
        end
        pending_q.push_back(res);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_cfg(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csm_pkg::CFG_W-1:0] data);
        row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(input logic [15:0] re, input logic [15:0] im, input bit known,
                            input logic [15:0] er, input logic [15:0] ei);
        row_t r;
        r.kind = known ? ROW_KNOWN : ROW_ITEM;
        r.re = re;
        r.im = im;
        r.exp_re = er;
        r.exp_im = ei;
        stim_rows.push_back(r);
    endtask

    // Result side: random stalls, stretches without stalls, one long hold-off.
    initial
    begin
        int      w;
        bit      held;
        sample_t want;
        held = 1'b0;
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 6);
            if (hold_req && !held)
            begin
                held = 1'b1;
                w = HOLD_LEN;
            end
            if (w > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dout_if.valid);
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result re=%0d im=%0d",
                             $signed(dout_if.out_re), $signed(dout_if.out_im));
            end
            else
            begin
                want = pending_q.pop_front();
                if (dout_if.out_re !== want.re || dout_if.out_im !== want.im)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                                 $signed(want.re), $signed(want.im),
                                 $signed(dout_if.out_re), $signed(dout_if.out_im));
                end
            end
        end
    end

    initial
    begin
        logic [csm_pkg::CFG_W-1:0] v;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        din_if.valid = 1'b0;
        din_if.in_re = '0;
        din_if.in_im = '0;
        rot_mode   = csm_pkg::MODE_COPY;
        rot_gain   = 4096;
        rot_swap   = 1'b0;
        rot_step   = '0;
        rot_offset = 0;
        rot_level  = 0;
        rot_bias   = 0;
        rot_acc    = '0;

        // Reset defaults pass samples through untouched.
        add_item(16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000);
        add_item(16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000);
        add_item(16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0001);
        // Largest gains saturate the products.
        add_cfg(csm_pkg::REG_GAIN, 32'h0000_7FFF);
        add_item(16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000);
        add_item(16'h0001, 16'hFFFF, 1'b0, '0, '0);
        add_cfg(csm_pkg::REG_GAIN, 32'h0000_8000);
        add_item(16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000);
        // Swap of I and Q, then the spare mode code behaving as copy.
        add_cfg(csm_pkg::REG_GAIN, 32'h0000_1000);
        add_cfg(csm_pkg::REG_IQ_SWAP, 32'h1);
        add_item(16'h0005, 16'hFFF9, 1'b1, 16'hFFF9, 16'h0005);
        add_cfg(csm_pkg::REG_MODE, 32'(MODE_SPARE));
        add_item(16'h0064, 16'h00C8, 1'b1, 16'h00C8, 16'h0064);
        // A write to an unused index changes nothing.
        add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        add_item(16'h1234, 16'h8765, 1'b1, 16'h8765, 16'h1234);
        add_cfg(csm_pkg::REG_IQ_SWAP, 32'h0);
        add_cfg(csm_pkg::REG_MODE, 32'(csm_pkg::MODE_SHIFT));
        add_cfg(csm_pkg::REG_PHASE_STEP, 32'h4000_0000);
        add_item(16'h7FFF, 16'h0000, 1'b0, '0, '0);
        add_item(16'h7FFF, 16'h7FFF, 1'b0, '0, '0);
        add_item(16'h8000, 16'h8000, 1'b0, '0, '0);
        add_cfg(csm_pkg::REG_PHASE_STEP, 32'h8000_0000);
        add_item(16'h4000, 16'hC000, 1'b0, '0, '0);
        add_item(16'h4000, 16'hC000, 1'b0, '0, '0);
        add_cfg(csm_pkg::REG_MODE, 32'(csm_pkg::MODE_PM));
        add_cfg(csm_pkg::REG_PM_LEVEL, 32'h0000_7FFF);
        add_cfg(csm_pkg::REG_PM_BIAS, 32'h0000_7FFF);
        add_cfg(csm_pkg::REG_PM_OFFSET, 32'h0000_8000);
        add_item(16'h7FFF, 16'h8000, 1'b0, '0, '0);
        add_item(16'h2000, 16'h1000, 1'b0, '0, '0);
        add_cfg(csm_pkg::REG_PM_LEVEL, 32'h0000_8000);
        add_cfg(csm_pkg::REG_PM_BIAS, 32'h0000_8000);
        add_cfg(csm_pkg::REG_PM_OFFSET, 32'h0000_7FFF);
        add_item(16'h7FFF, 16'h7FFF, 1'b0, '0, '0);
        add_item(16'h8000, 16'h0001, 1'b0, '0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_CFG)
            begin
                settle();
                write_reg(stim_rows[k].idx, stim_rows[k].data);
                cfg_we <= 1'b0;
            end
            else
                send_sample(stim_rows[k].re, stim_rows[k].im,
                            stim_rows[k].kind == ROW_KNOWN,
                            stim_rows[k].exp_re, stim_rows[k].exp_im);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            v = $urandom_range(0, 3);
            write_reg(csm_pkg::REG_MODE, (p < 3) ? 32'(p) : v);
            v = {16'($urandom), pick16()};
            write_reg(csm_pkg::REG_GAIN, ($urandom_range(0, 2) == 0) ? 32'h1000 : v);
            write_reg(csm_pkg::REG_IQ_SWAP, $urandom);
            v = $urandom;
            case ($urandom_range(0, 4))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'($urandom_range(0, 65535)) - 32'd32768;
                default: ;
            endcase
            write_reg(csm_pkg::REG_PHASE_STEP, v);
            write_reg(csm_pkg::REG_PM_OFFSET, {16'($urandom), pick16()});
            write_reg(csm_pkg::REG_PM_LEVEL, {16'($urandom), pick16()});
            write_reg(csm_pkg::REG_PM_BIAS, {16'($urandom), pick16()});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom);
            cfg_we <= 1'b0;
            no_idle = (p % 4 == 3);
            if (p == 5)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // In one phase only, the sender waits out every result midway through.
                if (p == 7 && n == PHASE_LEN / 2)
                    settle();
                send_sample(pick16(), pick16(), 1'b0, '0, '0);
            end
            no_idle = 1'b0;
        end

        settle();
        if (errors == 0)
            $display("[complex_shift_pm_modulator] OK");
        else
            $display("[complex_shift_pm_modulator] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/csm_pkg.sv
hw/rtl/csm_if.sv
hw/rtl/csm_datapath.sv
hw/rtl/csm_ctrl.sv
hw/rtl/complex_shift_pm_modulator.sv
tb/complex_shift_pm_modulator_tb.sv
